// File: sv/rotator_position_frame_encoder_assert.svh
// assertion macros shared by the frame encoder modules
`ifndef ROTATOR_POSITION_FRAME_ENCODER_ASSERT_SVH
`define ROTATOR_POSITION_FRAME_ENCODER_ASSERT_SVH
`ifndef SYNTH
`define RPFE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rpfe assertion failed");
`define RPFE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rpfe assertion failed");
`else
`define RPFE_ASSERT(label, prop)
`define RPFE_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: sv/rpfe_pkg.sv
// types and constants of the rotator position frame encoder
package rpfe_pkg;

    localparam int FRAME_LEN = 48;
    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] CK_IDX = IDX_W'(FRAME_LEN - 2);

    localparam int ANGLE_W = 10;
    localparam logic [ANGLE_W-1:0] ANGLE_ZERO = '0;
    localparam logic [ANGLE_W-1:0] EL_UP = 10'd90;
    localparam logic [ANGLE_W-1:0] AZ_CW = 10'd180;
    localparam logic [ANGLE_W-1:0] DIGIT_MOD = 10'd1000;

    localparam logic [7:0] RST_STATUS = 8'b1010_0001;
    localparam logic [7:0] RST_AZ_DRIVE = 8'd164;
    localparam logic [7:0] RST_EL_DRIVE = 8'd46;
    localparam logic [7:0] RST_AZ_DB = 8'h01;
    localparam logic [7:0] RST_EL_DB = 8'h01;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_DOT = 8'h2e;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_Z = 8'h5a;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_L = 8'h4c;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_D = 8'h44;

    typedef enum logic [2:0] {
        OP_SET  = 3'd0,
        OP_PARK = 3'd1,
        OP_UP   = 3'd2,
        OP_DOWN = 3'd3,
        OP_CCW  = 3'd4,
        OP_CW   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CFG_STATUS   = 3'd0,
        CFG_AZ_DRIVE = 3'd1,
        CFG_EL_DRIVE = 3'd2,
        CFG_AZ_DB    = 3'd3,
        CFG_EL_DB    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic               bad;
        logic [ANGLE_W-1:0] az;
        logic [ANGLE_W-1:0] el;
    } entry_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] az_drive;
        logic [7:0] el_drive;
        logic [7:0] az_db;
        logic [7:0] el_db;
    } cfg_t;

endpackage

// File: sv/rotator_position_frame_encoder.sv
// top level of the rotator position frame encoder
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | op, az_target, el_target
//  out      | out_valid / out_ready| frame_byte, last_byte, bad_op, cur_az, cur_el
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a valid command gives 48 bytes at one transfer per cycle while out_ready is high, an invalid one a single result
// frames follow back to back when a command is queued: byte 0 of the next frame comes in the cycle after byte 47
// a two-entry queue takes commands while a frame is streaming; in_ready drops when it is full
// out stalls freeze the byte counter; digit split runs in the first cycles of each frame
// reset clears target position, queue and byte counter and loads the register defaults
module rotator_position_frame_encoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   op,
    input  logic [rpfe_pkg::ANGLE_W-1:0] az_target,
    input  logic [rpfe_pkg::ANGLE_W-1:0] el_target,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   frame_byte,
    output logic                         last_byte,
    output logic                         bad_op,
    output logic [rpfe_pkg::ANGLE_W-1:0] cur_az,
    output logic [rpfe_pkg::ANGLE_W-1:0] cur_el,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [7:0]                   cfg_data
);

    rpfe_pkg::cfg_t   cfg_reg;
    rpfe_pkg::entry_t push_entry;
    rpfe_pkg::entry_t q_entry;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.status <= rpfe_pkg::RST_STATUS;
            cfg_reg.az_drive <= rpfe_pkg::RST_AZ_DRIVE;
            cfg_reg.el_drive <= rpfe_pkg::RST_EL_DRIVE;
            cfg_reg.az_db <= rpfe_pkg::RST_AZ_DB;
            cfg_reg.el_db <= rpfe_pkg::RST_EL_DB;
        end
        else if (cfg_valid)
        begin
            case (rpfe_pkg::cfg_idx_t'(cfg_index))
                rpfe_pkg::CFG_STATUS:   cfg_reg.status <= cfg_data;
                rpfe_pkg::CFG_AZ_DRIVE: cfg_reg.az_drive <= cfg_data;
                rpfe_pkg::CFG_EL_DRIVE: cfg_reg.el_drive <= cfg_data;
                rpfe_pkg::CFG_AZ_DB:    cfg_reg.az_db <= cfg_data;
                rpfe_pkg::CFG_EL_DB:    cfg_reg.el_db <= cfg_data;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    rpfe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .az_target  (az_target),
        .el_target  (el_target),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    rpfe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    rpfe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop),
        .cfg        (cfg_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .bad_op     (bad_op),
        .cur_az     (cur_az),
        .cur_el     (cur_el)
    );

endmodule

// File: sv/rpfe_front.sv
// command front end: resolves op codes and keeps the target position
module rpfe_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        op,
    input  logic [rpfe_pkg::ANGLE_W-1:0]      az_target,
    input  logic [rpfe_pkg::ANGLE_W-1:0]      el_target,
    input  logic                              q_full,
    output logic                              push,
    output rpfe_pkg::entry_t                  push_entry
);

    logic [rpfe_pkg::ANGLE_W-1:0] az_reg;
    logic [rpfe_pkg::ANGLE_W-1:0] el_reg;
    logic [rpfe_pkg::ANGLE_W-1:0] az_next;
    logic [rpfe_pkg::ANGLE_W-1:0] el_next;
    logic                         bad;

    always_comb
    begin
        bad = 1'b0;
        az_next = az_reg;
        el_next = el_reg;
        case (rpfe_pkg::op_t'(op))
            rpfe_pkg::OP_SET:
            begin
                az_next = az_target;
                el_next = el_target;
            end
            rpfe_pkg::OP_PARK:
            begin
                az_next = rpfe_pkg::ANGLE_ZERO;
                el_next = rpfe_pkg::ANGLE_ZERO;
            end
            rpfe_pkg::OP_UP:   el_next = rpfe_pkg::EL_UP;
            rpfe_pkg::OP_DOWN: el_next = rpfe_pkg::ANGLE_ZERO;
            rpfe_pkg::OP_CCW:  az_next = rpfe_pkg::ANGLE_ZERO;
            rpfe_pkg::OP_CW:   az_next = rpfe_pkg::AZ_CW;
            default:           bad = 1'b1;
        endcase
    end

    assign in_ready = !q_full;
    assign push = in_valid && !q_full;
    assign push_entry = '{bad: bad, az: az_next, el: el_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_reg <= '0;
            el_reg <= '0;
        end
        else if (push && !bad)
        begin
            az_reg <= az_next;
            el_reg <= el_next;
        end
    end

endmodule

// File: sv/rpfe_queue.sv
// two-entry command queue between front end and frame generator
module rpfe_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rpfe_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output rpfe_pkg::entry_t q_entry
);

    `include "rotator_position_frame_encoder_assert.svh"

    rpfe_pkg::entry_t mem [2];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_reg;
    logic             rd_reg;

    assign full = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = mem[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_entry;
    end

    `RPFE_ASSERT(a_no_push_full, !(push && full))
    `RPFE_ASSERT(a_no_pop_empty, !(pop && !q_valid))
    `RPFE_ASSERT(a_ptr_count, (count_reg == 2'd1) == (wr_reg != rd_reg))

endmodule

// File: sv/rpfe_back.sv
// frame generator: digit split, byte sequencing and running checksum
module rpfe_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  rpfe_pkg::entry_t             q_entry,
    output logic                         pop,
    input  rpfe_pkg::cfg_t               cfg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   frame_byte,
    output logic                         last_byte,
    output logic                         bad_op,
    output logic [rpfe_pkg::ANGLE_W-1:0] cur_az,
    output logic [rpfe_pkg::ANGLE_W-1:0] cur_el
);

    `include "rotator_position_frame_encoder_assert.svh"

    logic                         valid_reg;
    logic [rpfe_pkg::IDX_W-1:0]   idx_reg;
    logic [7:0]                   ck_reg;
    logic                         bad_reg;
    logic [rpfe_pkg::ANGLE_W-1:0] az_reg;
    logic [rpfe_pkg::ANGLE_W-1:0] el_reg;

    // lane 0 azimuth, lane 1 elevation
    logic [9:0]  r_reg    [2];
    logic [3:0]  hund_reg [2];
    logic [6:0]  rem_reg  [2];
    logic [3:0]  tens_reg [2];
    logic [6:0]  ones     [2];
    logic [15:0] hund_prod [2];
    logic [9:0]  hund_x100 [2];
    logic [9:0]  rem_full  [2];
    logic [13:0] tens_prod [2];
    logic [9:0]  r_next    [2];
    logic [9:0]  ld_val    [2];

    logic xfer;
    logic load;
    logic [7:0] byte_val;

    assign xfer = valid_reg && out_ready;
    assign load = q_valid && (!valid_reg || (xfer && last_byte));
    assign pop = load;

    assign out_valid = valid_reg;
    assign last_byte = bad_reg || (idx_reg == rpfe_pkg::LAST_IDX);
    assign bad_op = bad_reg;
    assign cur_az = az_reg;
    assign cur_el = el_reg;
    assign frame_byte = bad_reg ? 8'd0 : byte_val;

    assign ld_val[0] = q_entry.az;
    assign ld_val[1] = q_entry.el;

    // reciprocal multiplies: x/100 = (x*41)>>12 for x<1000, x/10 = (x*103)>>10 for x<100
    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            r_next[g] = (ld_val[g] >= rpfe_pkg::DIGIT_MOD) ?
                        (ld_val[g] - rpfe_pkg::DIGIT_MOD) : ld_val[g];
            hund_prod[g] = {6'd0, r_reg[g]} * 16'd41;
            hund_x100[g] = {6'd0, hund_reg[g]} * 10'd100;
            rem_full[g] = r_reg[g] - hund_x100[g];
            tens_prod[g] = {7'd0, rem_reg[g]} * 14'd103;
            ones[g] = rem_reg[g] - ({3'd0, tens_reg[g]} * 7'd10);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 2; g++)
        begin
            if (load)
                r_reg[g] <= r_next[g];
            hund_reg[g] <= hund_prod[g][15:12];
            rem_reg[g] <= rem_full[g][6:0];
            tens_reg[g] <= tens_prod[g][13:10];
        end
        if (load)
        begin
            bad_reg <= q_entry.bad;
            az_reg <= q_entry.az;
            el_reg <= q_entry.el;
        end
    end

    always_comb
    begin
        case (idx_reg)
            6'd0:  byte_val = rpfe_pkg::CH_START;
            6'd1:  byte_val = rpfe_pkg::CH_A;
            6'd2:  byte_val = rpfe_pkg::CH_Z;
            6'd3:  byte_val = rpfe_pkg::CH_ZERO | {4'd0, hund_reg[0]};
            6'd4:  byte_val = rpfe_pkg::CH_ZERO | {4'd0, tens_reg[0]};
            6'd5:  byte_val = rpfe_pkg::CH_ZERO | {4'd0, ones[0][3:0]};
            6'd6:  byte_val = rpfe_pkg::CH_E;
            6'd7:  byte_val = rpfe_pkg::CH_L;
            6'd8:  byte_val = rpfe_pkg::CH_ZERO | {4'd0, hund_reg[1]};
            6'd9:  byte_val = rpfe_pkg::CH_ZERO | {4'd0, tens_reg[1]};
            6'd10: byte_val = rpfe_pkg::CH_ZERO | {4'd0, ones[1][3:0]};
            6'd11: byte_val = rpfe_pkg::CH_U;
            6'd12: byte_val = rpfe_pkg::CH_L;
            6'd17, 6'd30: byte_val = rpfe_pkg::CH_DOT;
            6'd13, 6'd14, 6'd15, 6'd16, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
            6'd26, 6'd27, 6'd28, 6'd29, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36:
                byte_val = rpfe_pkg::CH_ZERO;
            6'd24: byte_val = rpfe_pkg::CH_D;
            6'd25: byte_val = rpfe_pkg::CH_L;
            6'd37: byte_val = cfg.status;
            6'd42: byte_val = cfg.az_drive;
            6'd43: byte_val = cfg.el_drive;
            6'd44: byte_val = cfg.az_db;
            6'd45: byte_val = cfg.el_db;
            6'd46: byte_val = ck_reg;
            6'd47: byte_val = rpfe_pkg::CH_END;
            default: byte_val = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
            ck_reg <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg <= '0;
            ck_reg <= '0;
        end
        else if (xfer)
        begin
            if (last_byte)
            begin
                valid_reg <= 1'b0;
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 6'd1;
                // checksum covers bytes 1 to 45
                if (idx_reg != 6'd0 && idx_reg < rpfe_pkg::CK_IDX)
                    ck_reg <= ck_reg ^ byte_val;
            end
        end
    end

    `RPFE_ASSERT_NEXT(a_idx_step, xfer && !last_byte,
                      valid_reg && idx_reg == $past(idx_reg) + 6'd1)
    `RPFE_ASSERT(a_bad_single, !(valid_reg && bad_reg && idx_reg != 6'd0))
    `RPFE_ASSERT(a_digits_dec, !(valid_reg && !bad_reg && idx_reg >= 6'd4) ||
                 (hund_reg[0] < 4'd10 && tens_reg[0] < 4'd10 && ones[0] < 7'd10 &&
                  hund_reg[1] < 4'd10 && tens_reg[1] < 4'd10 && ones[1] < 7'd10))
    `RPFE_ASSERT_NEXT(a_stall_hold, valid_reg && !out_ready && !bad_reg, valid_reg && $stable(idx_reg))

endmodule
